@@ src/mvf_pkg.sv @@
// Shared types, constants and helpers for the multichannel volume fader.
// Used by mvf_table, mvf_arith and multichannel_volume_fade; depends on nothing.
`default_nettype none

package mvf_pkg;

    localparam int CH_W        = 4;
    localparam int VOL_W       = 7;
    localparam int SECS_W      = 12;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 16;
    localparam int MAX_CH      = 16;
    localparam int DIV_STEPS   = 7;
    localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

    typedef enum logic [1:0] {
        MODE_PLAY = 2'd0,
        MODE_STOP = 2'd1,
        MODE_FADE = 2'd2,
        MODE_TICK = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_PLAY = 2'd0,
        KIND_STOP = 2'd1,
        KIND_STEP = 2'd2,
        KIND_FIN  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        TOP_NONE,
        TOP_PLAY,
        TOP_STOP,
        TOP_FADE,
        TOP_ELAPSED,
        TOP_SNAP,
        TOP_LEVEL
    } tbl_op_t;

    typedef struct packed {
        tbl_op_t          op;
        logic [VOL_W-1:0] level;
        logic             looping;
    } tbl_cmd_t;

    typedef struct packed {
        logic             fading;
        logic             play;
        logic             looping;
        logic [VOL_W-1:0] level;
        logic [VOL_W-1:0] start;
        logic [VOL_W-1:0] target;
    } chan_rd_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_DUR,
        MS_SCAN,
        MS_INTERP,
        MS_EMIT
    } main_state_t;

    typedef enum logic [0:0] {
        AOP_DUR,
        AOP_INTERP
    } arith_op_t;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL_D,
        AS_MUL_A,
        AS_MUL_B,
        AS_ADD,
        AS_PREP,
        AS_DIV,
        AS_DONE
    } arith_state_t;

    function automatic logic [VOL_W-1:0] sat_vol(input logic [VOL_W-1:0] v);
        return (v > VOL_MAX) ? VOL_MAX : v;
    endfunction

endpackage

`default_nettype wire

@@ src/mvf_table.sv @@
// Channel table: per-channel volume, flags and fade state in registers.
// Depends on mvf_pkg for the command and read-out structures.
`default_nettype none

module mvf_table #(
    parameter int NCH   = 16,
    parameter int IDX_W = 4,
    parameter int DUR_W = 22
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  mvf_pkg::tbl_cmd_t     cmd,
    input  wire  [IDX_W-1:0]      wr_idx,
    input  wire  [DUR_W-1:0]      wr_elapsed,
    input  wire  [DUR_W-1:0]      wr_dur,
    input  wire  [IDX_W-1:0]      rd_idx,
    output mvf_pkg::chan_rd_t     rd,
    output logic [DUR_W-1:0]      rd_elapsed,
    output logic [DUR_W-1:0]      rd_dur,
    output logic [NCH-1:0]        fading_mask
);
    import mvf_pkg::*;

    logic                fading_reg  [NCH];
    logic                play_reg    [NCH];
    logic                loop_reg    [NCH];
    logic [VOL_W-1:0]    level_reg   [NCH];
    logic [VOL_W-1:0]    start_reg   [NCH];
    logic [VOL_W-1:0]    target_reg  [NCH];
    logic [DUR_W-1:0]    dur_reg     [NCH];
    logic [DUR_W-1:0]    elapsed_reg [NCH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCH; i++) begin
                fading_reg[i]  <= 1'b0;
                play_reg[i]    <= 1'b0;
                loop_reg[i]    <= 1'b0;
                level_reg[i]   <= '0;
                start_reg[i]   <= '0;
                target_reg[i]  <= '0;
                dur_reg[i]     <= '0;
                elapsed_reg[i] <= '0;
            end
        end else begin
            case (cmd.op)
                TOP_PLAY: begin
                    loop_reg[wr_idx]  <= cmd.looping;
                    level_reg[wr_idx] <= cmd.level;
                    play_reg[wr_idx]  <= 1'b1;
                end
                TOP_STOP: begin
                    play_reg[wr_idx] <= 1'b0;
                end
                TOP_FADE: begin
                    fading_reg[wr_idx]  <= 1'b1;
                    start_reg[wr_idx]   <= level_reg[wr_idx];
                    target_reg[wr_idx]  <= cmd.level;
                    dur_reg[wr_idx]     <= wr_dur;
                    elapsed_reg[wr_idx] <= '0;
                end
                TOP_ELAPSED: begin
                    elapsed_reg[wr_idx] <= wr_elapsed;
                end
                TOP_SNAP: begin
                    elapsed_reg[wr_idx] <= wr_elapsed;
                    level_reg[wr_idx]   <= target_reg[wr_idx];
                    fading_reg[wr_idx]  <= 1'b0;
                end
                TOP_LEVEL: begin
                    level_reg[wr_idx] <= cmd.level;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rd.fading  = fading_reg[rd_idx];
        rd.play    = play_reg[rd_idx];
        rd.looping = loop_reg[rd_idx];
        rd.level   = level_reg[rd_idx];
        rd.start   = start_reg[rd_idx];
        rd.target  = target_reg[rd_idx];
        rd_elapsed = elapsed_reg[rd_idx];
        rd_dur     = dur_reg[rd_idx];
        for (int i = 0; i < NCH; i++) begin
            fading_mask[i] = fading_reg[i];
        end
    end

endmodule

`default_nettype wire

@@ src/mvf_arith.sv @@
// Shared arithmetic unit: one multiplier plus add and subtract logic under a small sequencer.
// Computes fade length in ticks, or the rounded linear blend by restoring division.
`default_nettype none

module mvf_arith #(
    parameter int TICKS_PER_SECOND = 1000,
    parameter int TPS_W            = 10,
    parameter int DUR_W            = 22
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          start,
    input  mvf_pkg::arith_op_t           op,
    input  wire  [mvf_pkg::SECS_W-1:0]   secs,
    input  wire  [DUR_W-1:0]             e,
    input  wire  [DUR_W-1:0]             d,
    input  wire  [mvf_pkg::VOL_W-1:0]    tgt,
    input  wire  [mvf_pkg::VOL_W-1:0]    sta,
    output logic                         done,
    output logic [DUR_W-1:0]             dur,
    output logic [mvf_pkg::VOL_W-1:0]    quot
);
    import mvf_pkg::*;

    localparam int MB_W   = (TPS_W > VOL_W) ? TPS_W : VOL_W;
    localparam int PROD_W = DUR_W + MB_W;
    localparam int NUM_W  = DUR_W + 8;

    arith_state_t        state_reg, state_next;
    logic [2:0]          cnt_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [NUM_W-1:0]    acc_reg;
    logic [NUM_W-1:0]    rem_reg;
    logic [NUM_W-1:0]    dvs_reg;
    logic [VOL_W-1:0]    quot_reg;
    logic [DUR_W-1:0]    mul_a;
    logic [MB_W-1:0]     mul_b;
    logic [PROD_W-1:0]   prod;
    logic [NUM_W:0]      diff;

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign diff = {1'b0, rem_reg} - {1'b0, dvs_reg};
    assign dur  = prod_reg[DUR_W-1:0];
    assign quot = quot_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            AS_IDLE: begin
                if (start) begin
                    state_next = (op == AOP_DUR) ? AS_MUL_D : AS_MUL_A;
                end
            end
            AS_MUL_D: state_next = AS_DONE;
            AS_MUL_A: state_next = AS_MUL_B;
            AS_MUL_B: state_next = AS_ADD;
            AS_ADD:   state_next = AS_PREP;
            AS_PREP:  state_next = AS_DIV;
            AS_DIV: begin
                if (cnt_reg == 3'd0) begin
                    state_next = AS_DONE;
                end
            end
            AS_DONE:  state_next = AS_IDLE;
            default:  state_next = AS_IDLE;
        endcase
    end

    always_comb begin
        done  = 1'b0;
        mul_a = e;
        mul_b = MB_W'(tgt);
        case (state_reg)
            AS_MUL_D: begin
                mul_a = DUR_W'(secs);
                mul_b = MB_W'(TICKS_PER_SECOND);
            end
            AS_MUL_A: begin
                mul_a = e;
                mul_b = MB_W'(tgt);
            end
            AS_MUL_B: begin
                mul_a = d - e;
                mul_b = MB_W'(sta);
            end
            AS_DONE: begin
                done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == AS_PREP) begin
                cnt_reg <= 3'(DIV_STEPS - 1);
            end else if (state_reg == AS_DIV) begin
                cnt_reg <= cnt_reg - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            AS_MUL_D, AS_MUL_A: begin
                prod_reg <= prod;
            end
            AS_MUL_B: begin
                acc_reg  <= NUM_W'(prod_reg);
                prod_reg <= prod;
            end
            AS_ADD: begin
                acc_reg <= acc_reg + NUM_W'(prod_reg);
            end
            AS_PREP: begin
                rem_reg  <= {acc_reg[NUM_W-2:0], 1'b0} + NUM_W'(d);
                dvs_reg  <= NUM_W'({d, 7'd0});
                quot_reg <= '0;
            end
            AS_DIV: begin
                quot_reg <= {quot_reg[VOL_W-2:0], ~diff[NUM_W]};
                if (!diff[NUM_W]) begin
                    rem_reg <= diff[NUM_W-1:0];
                end
                dvs_reg <= {1'b0, dvs_reg[NUM_W-1:1]};
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/multichannel_volume_fade.sv @@
// A play or stop request writes the channel table when taken and is reported once the output
// register is free; a fade request has no report and ends when its length in ticks is written.
// A tick walks the channels in order: idle channels are skipped, and a channel whose fade ends or
// that steps (one multiply-accumulate pass and 7 division steps in the shared unit) is reported.
// Throughput: one request at a time; the next is taken once the previous one has finished.
// Reset (aresetn low, synchronous) clears every channel and empties the output register.
`default_nettype none

module multichannel_volume_fade #(
    parameter int NUM_CHANNELS     = 16,
    parameter int TICKS_PER_SECOND = 1000
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // channel[3:0], volume[10:4], loop[11], fade_seconds[23:12]
    input  wire  [mvf_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode[1:0]
    input  wire  [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // out_channel[3:0], out_volume[10:4], playing[11], looping[12], zero[15:13]
    output logic [mvf_pkg::M_TDATA_W-1:0]     m_tdata,
    // kind[1:0]
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    import mvf_pkg::*;

    localparam int NCH   = (NUM_CHANNELS < MAX_CH) ? NUM_CHANNELS : MAX_CH;
    localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int TPS_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int DUR_W = $clog2(4095 * TICKS_PER_SECOND + 2);

    main_state_t          state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    kind_t                kind_reg, kind_next;
    logic [VOL_W-1:0]     tgt_reg, tgt_next;
    logic [SECS_W-1:0]    secs_reg, secs_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [1:0]           m_tuser_reg;
    logic                 m_tlast_reg;

    logic [CH_W-1:0]      s_channel;
    logic [VOL_W-1:0]     s_volume;
    logic                 s_loop;
    logic [SECS_W-1:0]    s_secs;
    mode_t                s_mode;
    logic                 s_fire;
    logic                 in_range;
    logic                 out_free;
    logic                 idx_last;
    logic                 emit;
    logic                 emit_last;
    logic [NCH-1:0]       later_mask;

    tbl_cmd_t             cmd;
    logic [IDX_W-1:0]     wr_idx;
    chan_rd_t             rd;
    logic [DUR_W-1:0]     rd_elapsed;
    logic [DUR_W-1:0]     rd_dur;
    logic [DUR_W-1:0]     e_inc;
    logic [NCH-1:0]       fading_mask;

    logic                 arith_start;
    arith_op_t            arith_op;
    logic                 arith_done;
    logic [DUR_W-1:0]     arith_dur;
    logic [VOL_W-1:0]     arith_quot;

    assign s_channel = s_tdata[3:0];
    assign s_volume  = s_tdata[10:4];
    assign s_loop    = s_tdata[11];
    assign s_secs    = s_tdata[23:12];
    assign s_mode    = mode_t'(s_tuser);
    assign s_fire    = s_tvalid && s_tready;
    assign in_range  = int'(s_channel) < NUM_CHANNELS;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign idx_last  = (idx_reg == IDX_W'(NCH - 1));
    assign e_inc     = rd_elapsed + DUR_W'(1);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    mvf_table #(
        .NCH   (NCH),
        .IDX_W (IDX_W),
        .DUR_W (DUR_W)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .wr_idx      (wr_idx),
        .wr_elapsed  (e_inc),
        .wr_dur      (arith_dur),
        .rd_idx      (idx_reg),
        .rd          (rd),
        .rd_elapsed  (rd_elapsed),
        .rd_dur      (rd_dur),
        .fading_mask (fading_mask)
    );

    mvf_arith #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .TPS_W            (TPS_W),
        .DUR_W            (DUR_W)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (arith_start),
        .op      (arith_op),
        .secs    (secs_reg),
        .e       (rd_elapsed),
        .d       (rd_dur),
        .tgt     (rd.target),
        .sta     (rd.start),
        .done    (arith_done),
        .dur     (arith_dur),
        .quot    (arith_quot)
    );

    always_comb begin
        for (int j = 0; j < NCH; j++) begin
            later_mask[j] = fading_mask[j] && (IDX_W'(j) > idx_reg);
        end
        emit_last = (kind_reg == KIND_PLAY) || (kind_reg == KIND_STOP) || !(|later_mask);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            MS_IDLE: begin
                if (s_fire) begin
                    if (s_mode == MODE_TICK) begin
                        state_next = MS_SCAN;
                    end else if (in_range) begin
                        state_next = (s_mode == MODE_FADE) ? MS_DUR : MS_EMIT;
                    end
                end
            end
            MS_DUR: begin
                if (arith_done) begin
                    state_next = MS_IDLE;
                end
            end
            MS_SCAN: begin
                if (rd.fading) begin
                    state_next = (e_inc > rd_dur) ? MS_EMIT : MS_INTERP;
                end else if (idx_last) begin
                    state_next = MS_IDLE;
                end
            end
            MS_INTERP: begin
                if (arith_done) begin
                    state_next = MS_EMIT;
                end
            end
            MS_EMIT: begin
                if (out_free) begin
                    if (kind_reg == KIND_PLAY || kind_reg == KIND_STOP || idx_last) begin
                        state_next = MS_IDLE;
                    end else begin
                        state_next = MS_SCAN;
                    end
                end
            end
            default: state_next = MS_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.op      = TOP_NONE;
        cmd.level   = '0;
        cmd.looping = 1'b0;
        wr_idx      = idx_reg;
        arith_start = 1'b0;
        arith_op    = AOP_INTERP;
        emit        = 1'b0;
        idx_next    = idx_reg;
        kind_next   = kind_reg;
        tgt_next    = tgt_reg;
        secs_next   = secs_reg;
        case (state_reg)
            MS_IDLE: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    if (s_mode == MODE_TICK) begin
                        idx_next = '0;
                    end else if (in_range) begin
                        idx_next = s_channel[IDX_W-1:0];
                        wr_idx   = s_channel[IDX_W-1:0];
                        case (s_mode)
                            MODE_PLAY: begin
                                cmd.op      = TOP_PLAY;
                                cmd.level   = sat_vol(s_volume);
                                cmd.looping = s_loop;
                                kind_next   = KIND_PLAY;
                            end
                            MODE_STOP: begin
                                cmd.op    = TOP_STOP;
                                kind_next = KIND_STOP;
                            end
                            default: begin
                                tgt_next    = sat_vol(s_volume);
                                secs_next   = s_secs;
                                arith_start = 1'b1;
                                arith_op    = AOP_DUR;
                            end
                        endcase
                    end
                end
            end
            MS_DUR: begin
                arith_op = AOP_DUR;
                if (arith_done) begin
                    cmd.op    = TOP_FADE;
                    cmd.level = tgt_reg;
                end
            end
            MS_SCAN: begin
                if (rd.fading) begin
                    if (e_inc > rd_dur) begin
                        cmd.op    = TOP_SNAP;
                        kind_next = KIND_FIN;
                    end else begin
                        cmd.op      = TOP_ELAPSED;
                        arith_start = 1'b1;
                    end
                end else if (!idx_last) begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            MS_INTERP: begin
                if (arith_done) begin
                    cmd.op    = TOP_LEVEL;
                    cmd.level = sat_vol(arith_quot);
                    kind_next = KIND_STEP;
                end
            end
            MS_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (kind_reg != KIND_PLAY && kind_reg != KIND_STOP && !idx_last) begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= MS_IDLE;
            idx_reg      <= '0;
            kind_reg     <= KIND_PLAY;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            kind_reg  <= kind_next;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tgt_reg  <= tgt_next;
        secs_reg <= secs_next;
        if (emit) begin
            m_tdata_reg <= {3'b000, rd.looping, rd.play, rd.level, CH_W'(idx_reg)};
            m_tuser_reg <= kind_reg;
            m_tlast_reg <= emit_last;
        end
    end

    a_done_when_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        arith_done |-> (state_reg == MS_DUR || state_reg == MS_INTERP))
        else $error("Arithmetic unit finished while the sequencer was not waiting.");

    a_play_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_range && s_mode == MODE_PLAY) |=> (state_reg == MS_EMIT))
        else $error("Accepted play request did not lead to a report.");

    a_volume_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:4] <= VOL_MAX))
        else $error("Reported volume exceeds the maximum.");

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == MS_INTERP && arith_done) |-> (arith_quot <= VOL_MAX))
        else $error("Interpolated volume out of range.");

endmodule

`default_nettype wire

@@ tb/multichannel_volume_fade_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for multichannel_volume_fade: play, stop, fade and tick requests
// are checked against a behavioural channel table. Depends on mvf_pkg and the fader RTL.
module multichannel_volume_fade_test;
    import mvf_pkg::*;

    localparam int TICKS_PER_SEC = 1000;
    localparam int CHANNELS      = 16;
    localparam int RANDOM_ITEMS  = 128;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 100;
    localparam int MAX_SHOWN     = 10;

    typedef struct {
        mode_t             mode;
        logic [CH_W-1:0]   channel;
        logic [VOL_W-1:0]  volume;
        logic              loop_on;
        logic [SECS_W-1:0] seconds;
    } fade_request_t;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [VOL_W-1:0] volume;
        logic             playing;
        logic             looping;
        kind_t            kind;
        logic             last;
    } channel_report_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [1:0]           s_tuser  = '0;
    logic                 m_tready = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [M_TDATA_W-1:0] m_tdata;
    wire  [1:0]           m_tuser;
    wire                  m_tlast;

    logic              ch_fading  [CHANNELS];
    logic [VOL_W-1:0]  ch_start   [CHANNELS];
    logic [VOL_W-1:0]  ch_target  [CHANNELS];
    logic [SECS_W-1:0] ch_secs    [CHANNELS];
    logic [21:0]       ch_elapsed [CHANNELS];
    logic [VOL_W-1:0]  ch_level   [CHANNELS];
    logic              ch_play    [CHANNELS];
    logic              ch_loop    [CHANNELS];

    fade_request_t   queued_requests[$];
    fade_request_t   active_req;
    channel_report_t awaited_reports[$];
    channel_report_t seen, wanted;
    int              mismatches = 0;
    int              cycles = 0;
    int              src_hold = 0;
    int              sink_hold = 0;
    bit              steady_phase = 1'b0;

    multichannel_volume_fade u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic channel_report_t channel_report(input int idx, input kind_t kind);
        channel_report_t rep;
        rep.channel = CH_W'(idx);
        rep.volume  = ch_level[idx];
        rep.playing = ch_play[idx];
        rep.looping = ch_loop[idx];
        rep.kind    = kind;
        rep.last    = 1'b0;
        return rep;
    endfunction

    function automatic void predict_reports(input fade_request_t req);
        channel_report_t   batch[$];
        longint unsigned   span, e, blend;
        logic [VOL_W-1:0]  vol;
        int                c;
        vol = (req.volume > VOL_MAX) ? VOL_MAX : req.volume;
        c = int'(req.channel);
        case (req.mode)
            MODE_PLAY: begin
                ch_loop[c]  = req.loop_on;
                ch_level[c] = vol;
                ch_play[c]  = 1'b1;
                batch.push_back(channel_report(c, KIND_PLAY));
            end
            MODE_STOP: begin
                ch_play[c] = 1'b0;
                batch.push_back(channel_report(c, KIND_STOP));
            end
            MODE_FADE: begin
                ch_fading[c]  = 1'b1;
                ch_start[c]   = ch_level[c];
                ch_target[c]  = vol;
                ch_secs[c]    = req.seconds;
                ch_elapsed[c] = '0;
            end
            default: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    if (ch_fading[i]) begin
                        span = longint'(ch_secs[i]) * TICKS_PER_SEC;
                        ch_elapsed[i] = ch_elapsed[i] + 1;
                        if (ch_elapsed[i] > span) begin
                            ch_level[i]  = ch_target[i];
                            ch_fading[i] = 1'b0;
                            batch.push_back(channel_report(i, KIND_FIN));
                        end else begin
                            e = ch_elapsed[i];
                            blend = e * ch_target[i] + (span - e) * ch_start[i];
                            blend = (2 * blend + span) / (2 * span);
                            ch_level[i] = (blend > VOL_MAX) ? VOL_MAX : blend[VOL_W-1:0];
                            batch.push_back(channel_report(i, KIND_STEP));
                        end
                    end
                end
            end
        endcase
        if (batch.size() > 0) begin
            batch[$].last = 1'b1;
        end
        foreach (batch[k]) begin
            awaited_reports.push_back(batch[k]);
        end
    endfunction

    function automatic void push_request(input mode_t mode, input int channel, input int volume,
                                         input bit loop_on, input int seconds);
        fade_request_t req;
        req.mode    = mode;
        req.channel = CH_W'(channel);
        req.volume  = VOL_W'(volume);
        req.loop_on = loop_on;
        req.seconds = SECS_W'(seconds);
        queued_requests.push_back(req);
    endfunction

    function automatic int rand_volume();
        return ($urandom_range(0, 19) < 17) ? $urandom_range(0, 100) : $urandom_range(101, 127);
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic wait_for_idle();
        while (queued_requests.size() > 0 || s_tvalid || awaited_reports.size() > 0) begin
            @(posedge aclk);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_reports(active_req);
            end
            if (!s_tvalid || s_tready) begin
                if (src_hold > 0) begin
                    src_hold = src_hold - 1;
                    s_tvalid <= 1'b0;
                end else if (queued_requests.size() > 0) begin
                    active_req = queued_requests.pop_front();
                    s_tdata <= {active_req.seconds, active_req.loop_on, active_req.volume,
                                active_req.channel};
                    s_tuser <= active_req.mode;
                    s_tvalid <= 1'b1;
                    if (!steady_phase && $urandom_range(0, 4) == 0) begin
                        src_hold = $urandom_range(1, 8);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen.channel = m_tdata[CH_W-1:0];
                seen.volume  = m_tdata[CH_W+VOL_W-1:CH_W];
                seen.playing = m_tdata[11];
                seen.looping = m_tdata[12];
                seen.kind    = kind_t'(m_tuser);
                seen.last    = m_tlast;
                if (awaited_reports.size() == 0) begin
                    log_mismatch($sformatf("unexpected report: ch %0d vol %0d kind %0d last %0b",
                                           seen.channel, seen.volume, seen.kind, seen.last));
                end else begin
                    wanted = awaited_reports.pop_front();
                    if (seen !== wanted || m_tdata[15:13] !== 3'b000) begin
                        log_mismatch($sformatf(
                            {"report mismatch: expected ch %0d vol %0d play %0b loop %0b ",
                             "kind %0d last %0b, got ch %0d vol %0d play %0b loop %0b ",
                             "kind %0d last %0b pad %b"},
                            wanted.channel, wanted.volume, wanted.playing, wanted.looping,
                            wanted.kind, wanted.last, seen.channel, seen.volume, seen.playing,
                            seen.looping, seen.kind, seen.last, m_tdata[15:13]));
                    end
                end
            end
            if (sink_hold > 0) begin
                sink_hold = sink_hold - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!steady_phase && $urandom_range(0, 5) == 0) begin
                    sink_hold = $urandom_range(1, 8);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("multichannel_volume_fade_test failed");
            $finish;
        end
    end

    initial begin
        int pick;
        int burst;
        int count;
        for (int i = 0; i < CHANNELS; i++) begin
            ch_fading[i]  = 1'b0;
            ch_start[i]   = '0;
            ch_target[i]  = '0;
            ch_secs[i]    = '0;
            ch_elapsed[i] = '0;
            ch_level[i]   = '0;
            ch_play[i]    = 1'b0;
            ch_loop[i]    = 1'b0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        push_request(MODE_PLAY, 0, 0, 1'b0, 0);
        push_request(MODE_PLAY, 15, 127, 1'b1, 4095);
        push_request(MODE_PLAY, 5, 100, 1'b1, 0);
        push_request(MODE_PLAY, 7, 101, 1'b0, 2730);
        push_request(MODE_STOP, 15, 0, 1'b0, 0);
        push_request(MODE_STOP, 0, 127, 1'b1, 4095);
        push_request(MODE_TICK, 0, 0, 1'b0, 0);
        push_request(MODE_FADE, 5, 0, 1'b1, 0);
        push_request(MODE_FADE, 0, 127, 1'b0, 4095);
        push_request(MODE_TICK, 0, 0, 1'b0, 0);
        push_request(MODE_STOP, 0, 0, 1'b0, 0);
        push_request(MODE_TICK, 9, 55, 1'b0, 1365);
        push_request(MODE_FADE, 0, 50, 1'b1, 2);
        push_request(MODE_PLAY, 0, 30, 1'b1, 0);
        push_request(MODE_TICK, 15, 127, 1'b1, 4095);
        push_request(MODE_FADE, 15, 100, 1'b0, 1);
        push_request(MODE_TICK, 0, 0, 1'b0, 0);
        push_request(MODE_STOP, 15, 100, 1'b0, 4095);
        push_request(MODE_FADE, 0, 0, 1'b0, 0);
        push_request(MODE_FADE, 15, 0, 1'b1, 0);
        push_request(MODE_TICK, 0, 0, 1'b0, 0);
        push_request(MODE_TICK, 0, 0, 1'b0, 0);

        count = 0;
        while (count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
                push_request(MODE_PLAY, $urandom_range(0, 15), rand_volume(),
                             $urandom_range(0, 1), $urandom_range(0, 4095));
                count++;
            end else if (pick < 30) begin
                push_request(MODE_STOP, $urandom_range(0, 15), $urandom_range(0, 127),
                             $urandom_range(0, 1), $urandom_range(0, 4095));
                count++;
            end else if (pick < 55) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: burst = 0;
                    4, 5, 6:    burst = $urandom_range(1, 3);
                    7, 8:       burst = $urandom_range(0, 4095);
                    default:    burst = 4095;
                endcase
                push_request(MODE_FADE, $urandom_range(0, 15), rand_volume(),
                             $urandom_range(0, 1), burst);
                count++;
            end else begin
                burst = $urandom_range(1, 6);
                repeat (burst) begin
                    push_request(MODE_TICK, $urandom_range(0, 15), $urandom_range(0, 127),
                                 $urandom_range(0, 1), $urandom_range(0, 4095));
                end
                count += burst;
            end
        end
        wait_for_idle();

        // Every channel gets a zero-length fade so that one tick reports all sixteen,
        // then two one-second fades take their first step together.
        steady_phase = 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
            push_request(MODE_FADE, i, rand_volume(), $urandom_range(0, 1), 0);
        end
        push_request(MODE_TICK, 0, 0, 1'b0, 0);
        push_request(MODE_FADE, 3, rand_volume(), 1'b0, 1);
        push_request(MODE_FADE, 12, rand_volume(), 1'b1, 1);
        push_request(MODE_TICK, $urandom_range(0, 15), $urandom_range(0, 127),
                     $urandom_range(0, 1), $urandom_range(0, 4095));
        wait_for_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (awaited_reports.size() > 0) begin
            log_mismatch($sformatf("%0d expected reports never arrived", awaited_reports.size()));
        end
        if (mismatches == 0) begin
            $display("multichannel_volume_fade_test passed");
        end else begin
            $display("multichannel_volume_fade_test failed");
        end
        $finish;
    end

endmodule
